// ===== src/phct_pkg.sv =====
package phct_pkg;

    // Table geometry.
    localparam int TABLE_SLOTS = 1024;
    localparam int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int COUNT_W     = $clog2(TABLE_SLOTS + 1);

    // Fixed field widths of the words on the ports.
    localparam int ADDR_W      = 32;
    localparam int ID_W        = 8;
    localparam int TIME_W      = 32;
    localparam int STATUS_W    = 3;
    localparam int SLOT_OUT_W  = 10;
    localparam int COUNT_OUT_W = 11;

    localparam logic [TIME_W-1:0] TTL_RESET = 32'd3600;

    // With a power-of-two size the home slot is just the low address bits.
    localparam bit SLOTS_POW2 = ((TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0);

    localparam logic [SLOT_W:0]    SLOTS_WIDE = (SLOT_W + 1)'(TABLE_SLOTS);
    localparam logic [SLOT_W-1:0]  SLOT_LAST  = SLOT_W'(TABLE_SLOTS - 1);
    localparam logic [COUNT_W-1:0] COUNT_FULL = COUNT_W'(TABLE_SLOTS);

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_FOUND   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_CREATED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ZERO    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_SWEEP   = 3'd4;

    typedef logic [SLOT_W-1:0]  slot_t;
    typedef logic [COUNT_W-1:0] count_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [ID_W-1:0]   service;
        logic [ID_W-1:0]   evt;
        logic [TIME_W-1:0] stamp;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Next slot of a probe sequence, wrapping at the end of the table.
    function automatic slot_t slot_inc(input slot_t i);
        return (i == SLOT_LAST) ? '0 : slot_t'(i + 1'b1);
    endfunction

    // One bit of a long division by the table size: shift in a bit and
    // subtract the size once if the partial remainder reached it.
    function automatic slot_t rem_step(input slot_t r, input logic b);
        logic [SLOT_W:0] t;
        t = {r, b};
        if (t >= SLOTS_WIDE)
        begin
            t = t - SLOTS_WIDE;
        end
        return t[SLOT_W-1:0];
    endfunction

endpackage

// ===== src/phct_if.sv =====
interface phct_req_if;
    import phct_pkg::*;

    logic                valid;
    logic                ready;
    logic                op;
    logic [ADDR_W-1:0]   ip_addr;
    logic [ID_W-1:0]     service_id;
    logic [ID_W-1:0]     event_id;
    logic [TIME_W-1:0]   now;

    modport source (output valid, op, ip_addr, service_id, event_id, now, input ready);
    modport sink   (input valid, op, ip_addr, service_id, event_id, now, output ready);
endinterface

interface phct_rsp_if;
    import phct_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [STATUS_W-1:0]    status;
    logic [SLOT_OUT_W-1:0]  slot;
    logic [TIME_W-1:0]      first_seen;
    logic [COUNT_OUT_W-1:0] removed_count;
    logic [COUNT_OUT_W-1:0] entries_in_use;

    modport source (output valid, status, slot, first_seen, removed_count, entries_in_use,
                    input ready);
    modport sink   (input valid, status, slot, first_seen, removed_count, entries_in_use,
                    output ready);
endinterface

// ===== src/phct_ram.sv =====
module phct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                           wr_data,
    input  logic                                       rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                           rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== src/probed_hash_counter_table_core.sv =====
// Channel   Dir  Word fields
// --------  ---  ---------------------------------------------------------------
// req       in   op, ip_addr, service_id, event_id, now
// rsp       out  status, slot, first_seen, removed_count, entries_in_use
// cfg       in   cfg_write_en, cfg_write_data (ttl_seconds, no read-back)
//
// A lookup that checks n slots reads them one after another from its home slot on;
// when the table size is not a power of two, the address is first reduced to its
// home slot in S_HASH. A sweep reads every slot in order. Both are set by the single
// read port of the entry memory, one slot per cycle. After reset a clearing pass
// zeroes every slot of the memory; req.ready stays low meanwhile. A finished word
// waits in the output register while the next request is taken; a stalled rsp
// holds only the completion of the item after.
module probed_hash_counter_table_core (
    input  logic                           clk,
    input  logic                           rst_n,
    phct_req_if.sink                       req,
    phct_rsp_if.source                     rsp,
    input  logic                           cfg_write_en,
    input  logic [phct_pkg::TIME_W-1:0]    cfg_write_data
);
    import phct_pkg::*;

    // One-hot controller states.
    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,  // zeroing the memory after reset
        S_IDLE  = 6'b000010,  // waiting for a request
        S_HASH  = 6'b000100,  // address mod table size, eight bits per cycle
        S_PROBE = 6'b001000,  // linear probe, one slot read per cycle
        S_SWEEP = 6'b010000,  // expiry walk over every slot
        S_DONE  = 6'b100000   // result staged, waiting for the output register
    } state_t;

    state_t               state_reg, state_next;
    logic [TIME_W-1:0]    ttl_reg, ttl_next;
    slot_t                idx_reg, idx_next;          // address of the read being issued
    slot_t                chk_idx_reg, chk_idx_next;  // slot whose data is on the read port
    logic                 pend_reg, pend_next;        // read data is valid this cycle
    slot_t                cnt_reg, cnt_next;          // slots checked so far in a probe
    count_t               occ_reg, occ_next;
    count_t               removed_reg, removed_next;

    // The key of the item in flight.
    logic [ADDR_W-1:0]    addr_reg, addr_next;
    logic [ID_W-1:0]      svc_reg, svc_next;
    logic [ID_W-1:0]      evt_reg, evt_next;
    logic [TIME_W-1:0]    now_reg, now_next;

    // Home slot reduction.
    logic [ADDR_W-1:0]    hash_sh_reg, hash_sh_next;
    slot_t                rem_reg, rem_next;
    logic [1:0]           step_reg, step_next;

    // Staged result.
    logic [STATUS_W-1:0]  res_status_reg, res_status_next;
    slot_t                res_slot_reg, res_slot_next;
    logic [TIME_W-1:0]    res_seen_reg, res_seen_next;

    // Output register.
    logic                   out_valid_reg, out_valid_next;
    logic                   out_load;
    logic [STATUS_W-1:0]    out_status_reg;
    logic [SLOT_OUT_W-1:0]  out_slot_reg;
    logic [TIME_W-1:0]      out_seen_reg;
    logic [COUNT_OUT_W-1:0] out_removed_reg;
    logic [COUNT_OUT_W-1:0] out_in_use_reg;

    // Memory port.
    logic                 ram_wr_en;
    slot_t                ram_wr_addr;
    entry_t               ram_wr_data;
    logic                 ram_rd_en;
    logic [ENTRY_W-1:0]   ram_rd_data;
    entry_t               rd_entry;

    logic                 hit;
    logic                 empty;
    logic                 expired;
    logic [TIME_W:0]      age;
    logic                 out_free;

    phct_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_SLOTS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (idx_reg),
        .rd_data (ram_rd_data)
    );

    assign rd_entry = entry_t'(ram_rd_data);

    // Slot compare against the key in flight. Address zero never reaches a
    // probe, so a hit is never an empty slot.
    assign hit   = (rd_entry.addr == addr_reg) && (rd_entry.service == svc_reg) &&
                   (rd_entry.evt == evt_reg);
    assign empty = (rd_entry.addr == '0);

    // The age is taken with a sign bit: an entry stamped later than now has a
    // negative age and never expires.
    assign age     = {1'b0, now_reg} - {1'b0, rd_entry.stamp};
    assign expired = !empty && !age[TIME_W] && (age[TIME_W-1:0] > ttl_reg);

    assign out_free = !out_valid_reg || rsp.ready;

    assign req.ready = (state_reg == S_IDLE);

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.slot           = out_slot_reg;
    assign rsp.first_seen     = out_seen_reg;
    assign rsp.removed_count  = out_removed_reg;
    assign rsp.entries_in_use = out_in_use_reg;

    always_comb
    begin
        slot_t r;

        state_next      = state_reg;
        ttl_next        = ttl_reg;
        idx_next        = idx_reg;
        chk_idx_next    = chk_idx_reg;
        pend_next       = pend_reg;
        cnt_next        = cnt_reg;
        occ_next        = occ_reg;
        removed_next    = removed_reg;
        addr_next       = addr_reg;
        svc_next        = svc_reg;
        evt_next        = evt_reg;
        now_next        = now_reg;
        hash_sh_next    = hash_sh_reg;
        rem_next        = rem_reg;
        step_next       = step_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_seen_next   = res_seen_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_load        = 1'b0;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = chk_idx_reg;
        ram_wr_data     = '0;
        ram_rd_en       = 1'b0;
        r               = rem_reg;

        if (cfg_write_en)
        begin
            ttl_next = cfg_write_data;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = idx_reg;
                idx_next    = slot_inc(idx_reg);
                if (idx_reg == SLOT_LAST)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (req.valid)
                begin
                    addr_next    = req.ip_addr;
                    svc_next     = req.service_id;
                    evt_next     = req.event_id;
                    now_next     = req.now;
                    removed_next = '0;
                    pend_next    = 1'b0;
                    cnt_next     = '0;
                    if (req.op)
                    begin
                        idx_next   = '0;
                        state_next = S_SWEEP;
                    end
                    else if (req.ip_addr == '0)
                    begin
                        res_status_next = ST_ZERO;
                        res_slot_next   = '0;
                        res_seen_next   = '0;
                        state_next      = S_DONE;
                    end
                    else if (SLOTS_POW2)
                    begin
                        idx_next   = req.ip_addr[SLOT_W-1:0];
                        state_next = S_PROBE;
                    end
                    else
                    begin
                        hash_sh_next = req.ip_addr;
                        rem_next     = '0;
                        step_next    = '0;
                        state_next   = S_HASH;
                    end
                end
            end

            S_HASH:
            begin
                // Eight bits of the address, most significant first.
                for (int k = 0; k < 8; k++)
                begin
                    r = rem_step(r, hash_sh_reg[ADDR_W-1-k]);
                end
                rem_next     = r;
                hash_sh_next = hash_sh_reg << 8;
                step_next    = step_reg + 2'd1;
                if (step_reg == 2'd3)
                begin
                    idx_next   = r;
                    state_next = S_PROBE;
                end
            end

            S_PROBE:
            begin
                // Reads run one slot ahead of the compare; the extra read after
                // the probe stops is dropped.
                ram_rd_en    = 1'b1;
                idx_next     = slot_inc(idx_reg);
                chk_idx_next = idx_reg;
                pend_next    = 1'b1;
                if (pend_reg)
                begin
                    if (hit)
                    begin
                        res_status_next = ST_FOUND;
                        res_slot_next   = chk_idx_reg;
                        res_seen_next   = rd_entry.stamp;
                        state_next      = S_DONE;
                    end
                    else if (empty)
                    begin
                        if (occ_reg >= COUNT_FULL)
                        begin
                            res_status_next = ST_FULL;
                            res_slot_next   = '0;
                            res_seen_next   = '0;
                        end
                        else
                        begin
                            ram_wr_en           = 1'b1;
                            ram_wr_data.addr    = addr_reg;
                            ram_wr_data.service = svc_reg;
                            ram_wr_data.evt     = evt_reg;
                            ram_wr_data.stamp   = now_reg;
                            occ_next            = occ_reg + 1'b1;
                            res_status_next     = ST_CREATED;
                            res_slot_next       = chk_idx_reg;
                            res_seen_next       = now_reg;
                        end
                        state_next = S_DONE;
                    end
                    else if (cnt_reg == SLOT_LAST)
                    begin
                        // Every slot checked, none free and no match.
                        res_status_next = ST_FULL;
                        res_slot_next   = '0;
                        res_seen_next   = '0;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end

            S_SWEEP:
            begin
                // Read slot i+1 while slot i is written back, so the two
                // addresses never collide.
                ram_rd_en    = 1'b1;
                idx_next     = slot_inc(idx_reg);
                chk_idx_next = idx_reg;
                pend_next    = 1'b1;
                if (pend_reg)
                begin
                    if (expired)
                    begin
                        ram_wr_en    = 1'b1;
                        removed_next = removed_reg + 1'b1;
                        if (occ_reg != '0)
                        begin
                            occ_next = occ_reg - 1'b1;
                        end
                    end
                    if (chk_idx_reg == SLOT_LAST)
                    begin
                        res_status_next = ST_SWEEP;
                        res_slot_next   = '0;
                        res_seen_next   = '0;
                        state_next      = S_DONE;
                    end
                end
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            ttl_reg       <= TTL_RESET;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ttl_reg       <= ttl_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_idx_reg    <= chk_idx_next;
        cnt_reg        <= cnt_next;
        removed_reg    <= removed_next;
        addr_reg       <= addr_next;
        svc_reg        <= svc_next;
        evt_reg        <= evt_next;
        now_reg        <= now_next;
        hash_sh_reg    <= hash_sh_next;
        rem_reg        <= rem_next;
        step_reg       <= step_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_seen_reg   <= res_seen_next;
    end

    // The counts go out at the port width; the item's occupancy is final
    // by the time the result is staged.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_status_reg  <= res_status_reg;
            out_slot_reg    <= SLOT_OUT_W'(res_slot_reg);
            out_seen_reg    <= res_seen_reg;
            out_removed_reg <= COUNT_OUT_W'(removed_reg);
            out_in_use_reg  <= COUNT_OUT_W'(occ_reg);
        end
    end

endmodule

// ===== src/phct_checker.sv =====
module phct_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               req_valid,
    input  logic                               req_ready,
    input  logic                               rsp_valid,
    input  logic                               rsp_ready,
    input  logic [phct_pkg::STATUS_W-1:0]      rsp_status,
    input  logic [phct_pkg::SLOT_OUT_W-1:0]    rsp_slot,
    input  logic [phct_pkg::TIME_W-1:0]        rsp_first_seen,
    input  logic [phct_pkg::COUNT_OUT_W-1:0]   rsp_removed_count
);
    import phct_pkg::*;

    // One item at a time: ready drops right after a request is taken.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request accepted while another item is in flight");

    // A stalled result word holds its status.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status)))
        else $error("result word changed while stalled");

    // Rejected lookups carry no slot, stamp or removal count.
    a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp_status == ST_FULL || rsp_status == ST_ZERO)) |->
        (rsp_slot == '0 && rsp_first_seen == '0 && rsp_removed_count == '0))
        else $error("rejected lookup carries nonzero fields");

    // Only a sweep reports removals, and a sweep reports no slot.
    a_sweep_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |->
        ((rsp_status == ST_SWEEP) ? (rsp_slot == '0 && rsp_first_seen == '0)
                                  : (rsp_removed_count == '0)))
        else $error("sweep and lookup fields mixed");

endmodule

bind probed_hash_counter_table_core phct_checker u_phct_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .req_valid         (req.valid),
    .req_ready         (req.ready),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_status        (rsp.status),
    .rsp_slot          (rsp.slot),
    .rsp_first_seen    (rsp.first_seen),
    .rsp_removed_count (rsp.removed_count)
);

// ===== tb/sv/testbench.sv =====
package phct_tb_pkg;
    import phct_pkg::*;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_SWEEP  = 1'b1;

    // Past this many mismatches the count goes on but the log stays short.
    localparam int MAX_REPORTS = 40;

    typedef struct packed {
        logic              op;
        logic [ADDR_W-1:0] ip_addr;
        logic [ID_W-1:0]   service_id;
        logic [ID_W-1:0]   event_id;
        logic [TIME_W-1:0] now;
    } request_t;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [SLOT_OUT_W-1:0]  slot;
        logic [TIME_W-1:0]      first_seen;
        logic [COUNT_OUT_W-1:0] removed_count;
        logic [COUNT_OUT_W-1:0] entries_in_use;
    } outcome_t;

    class hash_table_scoreboard;
        bit [ADDR_W-1:0] slot_addr    [TABLE_SLOTS];
        bit [ID_W-1:0]   slot_service [TABLE_SLOTS];
        bit [ID_W-1:0]   slot_event   [TABLE_SLOTS];
        bit [TIME_W-1:0] slot_stamp   [TABLE_SLOTS];
        int unsigned     occupied;
        bit [TIME_W-1:0] ttl;
        outcome_t        pending_outcomes[$];
        int              mismatches;
        int              words_noted;
        int              results_checked;
        int              status_count [8];
        int unsigned     swept_total;

        function new();
            ttl = TTL_RESET;
        endfunction

        function void set_ttl(input bit [TIME_W-1:0] value);
            ttl = value;
        endfunction

        function int outstanding();
            return pending_outcomes.size();
        endfunction

        // Applies one word to the table copy and returns the result it must produce.
        function outcome_t predict_outcome(input request_t w);
            outcome_t    r;
            int unsigned home;
            int unsigned idx;
            int unsigned removed;
            bit          done;
            bit          hit;
            r = '0;
            if (w.op == OP_SWEEP)
            begin
                removed = 0;
                for (int i = 0; i < TABLE_SLOTS; i++)
                begin
                    // A stamp later than now is a negative age and never expires.
                    if (slot_addr[i] != '0 && w.now > slot_stamp[i]
                        && w.now - slot_stamp[i] > ttl)
                    begin
                        slot_addr[i]    = '0;
                        slot_service[i] = '0;
                        slot_event[i]   = '0;
                        slot_stamp[i]   = '0;
                        if (occupied > 0)
                        begin
                            occupied--;
                        end
                        removed++;
                    end
                end
                r.status        = ST_SWEEP;
                r.removed_count = COUNT_OUT_W'(removed);
                swept_total += removed;
            end
            else if (w.ip_addr == '0)
            begin
                r.status = ST_ZERO;
            end
            else
            begin
                home = w.ip_addr % TABLE_SLOTS;
                idx  = home;
                hit  = 1'b0;
                done = 1'b0;
                for (int i = 0; i < TABLE_SLOTS && !done; i++)
                begin
                    idx = (home + i) % TABLE_SLOTS;
                    if (slot_addr[idx] == w.ip_addr && slot_service[idx] == w.service_id
                        && slot_event[idx] == w.event_id)
                    begin
                        hit  = 1'b1;
                        done = 1'b1;
                    end
                    else if (slot_addr[idx] == '0)
                    begin
                        done = 1'b1;
                    end
                end
                if (hit)
                begin
                    r.status     = ST_FOUND;
                    r.slot       = SLOT_OUT_W'(idx);
                    r.first_seen = slot_stamp[idx];
                end
                else
                begin
                    r.status = ST_FULL;
                    done     = (occupied >= TABLE_SLOTS);
                    for (int i = 0; i < TABLE_SLOTS && !done; i++)
                    begin
                        idx = (home + i) % TABLE_SLOTS;
                        if (slot_addr[idx] == '0)
                        begin
                            slot_addr[idx]    = w.ip_addr;
                            slot_service[idx] = w.service_id;
                            slot_event[idx]   = w.event_id;
                            slot_stamp[idx]   = w.now;
                            occupied++;
                            r.status     = ST_CREATED;
                            r.slot       = SLOT_OUT_W'(idx);
                            r.first_seen = w.now;
                            done         = 1'b1;
                        end
                    end
                end
            end
            r.entries_in_use = COUNT_OUT_W'(occupied);
            return r;
        endfunction

        function void note_request(input request_t w);
            outcome_t r;
            r = predict_outcome(w);
            words_noted++;
            status_count[r.status]++;
            pending_outcomes.push_back(r);
        endfunction

        function void report(input string text);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
            begin
                $display("%s", text);
            end
            if (mismatches == MAX_REPORTS)
            begin
                $display("Further mismatches are counted but not shown.");
            end
        endfunction

        function void compare_field(input string field, input logic [63:0] want,
                                    input logic [63:0] got, input longint unsigned at_ns);
            if (got !== want)
            begin
                report($sformatf("%0d ns: %s expected %0d, got %0d", at_ns, field, want, got));
            end
        endfunction

        function void check_response(input outcome_t got, input longint unsigned at_ns);
            outcome_t want;
            results_checked++;
            if (pending_outcomes.size() == 0)
            begin
                report($sformatf("%0d ns: result with none expected, got status %0d slot %0d",
                                 at_ns, got.status, got.slot));
                return;
            end
            want = pending_outcomes.pop_front();
            compare_field("status", 64'(want.status), 64'(got.status), at_ns);
            compare_field("slot", 64'(want.slot), 64'(got.slot), at_ns);
            compare_field("first_seen", 64'(want.first_seen), 64'(got.first_seen), at_ns);
            compare_field("removed_count", 64'(want.removed_count),
                          64'(got.removed_count), at_ns);
            compare_field("entries_in_use", 64'(want.entries_in_use),
                          64'(got.entries_in_use), at_ns);
        endfunction
    endclass

endpackage

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import phct_pkg::*;
    import phct_tb_pkg::*;

    // The slowest correct run has every word walk the whole table (a sweep, or a
    // lookup in a crowded table) plus random stalls on both sides and the clearing
    // pass after reset, over roughly 570 words. The limit lies far above that run's
    // length, so it only ever ends a hung run.
    localparam int unsigned CYCLE_LIMIT   = 2_500_000;
    localparam int          LONG_HOLD     = 300;
    localparam int          SETTLE_CYCLES = 16;
    localparam int          DRAIN_CYCLES  = 64;
    localparam int          RANDOM_WORDS  = 550;
    localparam int          POOL_DEPTH    = 48;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [ID_W-1:0]   service;
        logic [ID_W-1:0]   evt;
    } flow_key_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_write_en;
    logic [TIME_W-1:0] cfg_write_data;

    phct_req_if req_bus ();
    phct_rsp_if rsp_bus ();

    probed_hash_counter_table_core u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .req            (req_bus),
        .rsp            (rsp_bus),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

    // Percentages of cycles in which each side holds back. They change between
    // phases, once the last word of a phase has been accepted.
    int send_idle_pct;
    int recv_idle_pct;

    // Raised by the stimulus to ask the receiver for one long hold-off; the
    // receiver counts the hold itself and clears the flag when it lets go.
    bit hold_request;

    // A running notion of the current second, so that sweeps find a mix of young
    // and old entries instead of all or nothing.
    logic [TIME_W-1:0] clock_now;
    logic [TIME_W-1:0] ttl_setting;

    // Keys seen recently, so that lookups often hit an existing entry.
    flow_key_t key_pool[$];

    // A few home slots that new keys crowd onto, which builds long probe chains
    // and wrap-around at the end of the table.
    int unsigned hot_home [4];

    hash_table_scoreboard table_model = new();

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Both channels are watched at the rising edge. A word accepted at an edge is
    // noted before any result at the same edge is checked; that result always
    // belongs to an earlier word.
    always @(posedge clk)
    begin
        request_t w;
        outcome_t r;
        if (rst_n && req_bus.valid && req_bus.ready)
        begin
            w.op         = req_bus.op;
            w.ip_addr    = req_bus.ip_addr;
            w.service_id = req_bus.service_id;
            w.event_id   = req_bus.event_id;
            w.now        = req_bus.now;
            table_model.note_request(w);
        end
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            r.status         = rsp_bus.status;
            r.slot           = rsp_bus.slot;
            r.first_seen     = rsp_bus.first_seen;
            r.removed_count  = rsp_bus.removed_count;
            r.entries_in_use = rsp_bus.entries_in_use;
            table_model.check_response(r, $time);
        end
    end

    // The receiver changes ready only at falling edges. A long hold, when asked
    // for, keeps ready low while the sender goes on offering words, so the block
    // fills up and has to stall its input.
    initial
    begin
        rsp_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                for (int held = 0; held < LONG_HOLD; held++)
                begin
                    rsp_bus.ready <= 1'b0;
                    @(negedge clk);
                end
                hold_request = 1'b0;
            end
            rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: a run that hangs is ended here.
    initial
    begin
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timed out after %0d cycles with %0d results still due.",
                 CYCLE_LIMIT, table_model.outstanding());
        $display("Verification failed");
        $finish;
    end

    // Offers one word and returns at the edge that accepts it. Valid is left high
    // so that back-to-back words need no gap; the next call, or a parking of the
    // channel, decides its value at the following falling edge.
    task automatic send_word(input request_t w);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_bus.valid <= 1'b0;
            @(negedge clk);
        end
        req_bus.valid      <= 1'b1;
        req_bus.op         <= w.op;
        req_bus.ip_addr    <= w.ip_addr;
        req_bus.service_id <= w.service_id;
        req_bus.event_id   <= w.event_id;
        req_bus.now        <= w.now;
        @(posedge clk);
        while (!req_bus.ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic send_lookup(input logic [ADDR_W-1:0] addr, input logic [ID_W-1:0] service,
                               input logic [ID_W-1:0] evt, input logic [TIME_W-1:0] stamp);
        request_t w;
        w.op         = OP_LOOKUP;
        w.ip_addr    = addr;
        w.service_id = service;
        w.event_id   = evt;
        w.now        = stamp;
        send_word(w);
    endtask

    // A sweep ignores the key fields, so they carry random values.
    task automatic send_sweep(input logic [TIME_W-1:0] stamp);
        request_t w;
        w.op         = OP_SWEEP;
        w.ip_addr    = $urandom;
        w.service_id = ID_W'($urandom);
        w.event_id   = ID_W'($urandom);
        w.now        = stamp;
        send_word(w);
    endtask

    // The TTL register is only written with the block idle: the request channel
    // is parked, every expected result has arrived, and a settling wait has passed.
    task automatic write_ttl(input logic [TIME_W-1:0] value);
        @(negedge clk);
        req_bus.valid <= 1'b0;
        while (table_model.outstanding() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= value;
        @(negedge clk);
        cfg_write_en   <= 1'b0;
        table_model.set_ttl(value);
        ttl_setting = value;
    endtask

    task automatic choose_hot_homes();
        for (int i = 0; i < 4; i++)
        begin
            hot_home[i] = $urandom_range(0, TABLE_SLOTS - 1);
        end
    endtask

    // Random traffic. Most lookups reuse a recent key or crowd a new key onto a hot
    // home slot, so that hits, long chains and chains cut by sweeps all occur; the
    // rest are near misses on a known address, zero addresses and fully random keys.
    task automatic run_random_words(input int count);
        request_t  w;
        flow_key_t k;
        int        pick;
        bit        fresh;
        for (int n = 0; n < count; n++)
        begin
            clock_now    = clock_now + $urandom_range(0, 12);
            pick         = $urandom_range(99);
            fresh        = 1'b1;
            w.op         = OP_LOOKUP;
            w.ip_addr    = $urandom;
            w.service_id = ID_W'($urandom);
            w.event_id   = ID_W'($urandom);
            w.now        = clock_now;
            if (pick < 6)
            begin
                w.op = OP_SWEEP;
                case ($urandom_range(3))
                    0:       w.now = clock_now;
                    1:       w.now = clock_now + $urandom_range(0, 2 * ttl_setting);
                    2:       w.now = clock_now - $urandom_range(0, 400);
                    default: w.now = $urandom;
                endcase
            end
            else if (pick < 50 && key_pool.size() != 0)
            begin
                k            = key_pool[$urandom_range(key_pool.size() - 1)];
                w.ip_addr    = k.addr;
                w.service_id = k.service;
                w.event_id   = k.evt;
                fresh        = 1'b0;
            end
            else if (pick < 74)
            begin
                w.ip_addr = ($urandom & 32'hFFFF_FC00) | hot_home[$urandom_range(3)];
            end
            else if (pick < 82 && key_pool.size() != 0)
            begin
                // Same address as a known key, but one of the two codes differs.
                k         = key_pool[$urandom_range(key_pool.size() - 1)];
                w.ip_addr = k.addr;
                if ($urandom_range(1) == 0)
                begin
                    w.service_id = k.service;
                end
                else
                begin
                    w.event_id = k.evt;
                end
            end
            else if (pick < 87)
            begin
                w.ip_addr = '0;
            end
            if (w.op == OP_LOOKUP && $urandom_range(19) == 0)
            begin
                w.now = $urandom;
            end
            if (w.op == OP_LOOKUP && fresh && w.ip_addr != '0)
            begin
                key_pool.push_back('{w.ip_addr, w.service_id, w.event_id});
                if (key_pool.size() > POOL_DEPTH)
                begin
                    void'(key_pool.pop_front());
                end
            end
            send_word(w);
        end
    endtask

    initial
    begin
        rst_n              = 1'b0;
        cfg_write_en       = 1'b0;
        cfg_write_data     = '0;
        req_bus.valid      = 1'b0;
        req_bus.op         = OP_LOOKUP;
        req_bus.ip_addr    = '0;
        req_bus.service_id = '0;
        req_bus.event_id   = '0;
        req_bus.now        = '0;
        hold_request       = 1'b0;
        send_idle_pct      = 22;
        recv_idle_pct      = 67;
        ttl_setting        = TTL_RESET;
        clock_now          = '0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed words, first under the TTL left by reset. The zero address is
        // ignored; the all-ones key lands in the last slot with a stamp just short
        // of the end of time, and is then found regardless of the time given.
        send_lookup(32'h0000_0000, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
        send_lookup(32'hFFFF_FFFF, 8'hFF, 8'hFF, 32'hFFFF_FFFE);
        send_lookup(32'hFFFF_FFFF, 8'hFF, 8'hFF, 32'd1);
        // Two keys share home slot 0; a key whose home is the last slot wraps past
        // them; the same address with another event code gets a slot of its own.
        send_lookup(32'h0000_0400, 8'h00, 8'h00, 32'd0);
        send_lookup(32'h0000_0800, 8'h00, 8'h00, 32'd5);
        send_lookup(32'h0000_03FF, 8'h01, 8'h02, 32'd10);
        send_lookup(32'h0000_0400, 8'h00, 8'h01, 32'd20);
        send_lookup(32'h0000_03FF, 8'h01, 8'h02, 32'd30);
        // Only the entry stamped at zero is past the TTL here; the one stamped near
        // the end of time has a negative age and stays. Clearing slot 0 cuts the
        // chain, so the key held in slot 1 is missed and stored a second time.
        send_sweep(32'd3604);
        send_lookup(32'h0000_0800, 8'h00, 8'h00, 32'd3605);
        send_lookup(32'h0000_03FF, 8'h01, 8'h02, 32'd3606);
        // With the largest TTL nothing can expire; with a TTL of zero a sweep at
        // time zero finds only negative ages, and one at the end of time clears all.
        write_ttl(32'hFFFF_FFFF);
        send_sweep(32'hFFFF_FFFF);
        write_ttl(32'd0);
        send_sweep(32'd0);
        send_sweep(32'hFFFF_FFFF);

        // Random traffic in three phases, each with its own TTL and hot slots:
        // a slow receiver, then a slow sender, then both at full speed with one
        // long receiver hold-off at the start.
        choose_hot_homes();
        write_ttl(32'd300);
        run_random_words(RANDOM_WORDS / 3);

        send_idle_pct = 67;
        recv_idle_pct = 22;
        choose_hot_homes();
        write_ttl($urandom_range(1, 2000));
        run_random_words(RANDOM_WORDS / 3);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        choose_hot_homes();
        write_ttl(32'd60);
        hold_request = 1'b1;
        run_random_words(RANDOM_WORDS - 2 * (RANDOM_WORDS / 3));

        @(negedge clk);
        req_bus.valid <= 1'b0;
        while (table_model.outstanding() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d words and %0d results, %0d of them mismatched.",
                 table_model.words_noted, table_model.results_checked,
                 table_model.mismatches);
        $display("Found %0d, created %0d, full %0d, zero %0d, sweeps %0d clearing %0d.",
                 table_model.status_count[ST_FOUND], table_model.status_count[ST_CREATED],
                 table_model.status_count[ST_FULL], table_model.status_count[ST_ZERO],
                 table_model.status_count[ST_SWEEP], table_model.swept_total);
        if (table_model.mismatches == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/phct_pkg.sv
src/phct_if.sv
src/phct_ram.sv
src/probed_hash_counter_table_core.sv
src/phct_checker.sv
tb/sv/testbench.sv
